[rtl/sdis_pkg.sv]
package sdis_pkg;

  // lookahead depth range and default
  localparam int unsigned LA_DEPTH_DEF = 9;
  localparam int unsigned LA_MAX       = 16;
  localparam int unsigned LA_IDX_W     = $clog2(LA_MAX);
  localparam int unsigned LA_CNT_W     = $clog2(LA_MAX + 1);
  localparam int unsigned BEAT_CNT_W   = LA_CNT_W + 1;

  // queue between parser and emitter
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  // module header
  localparam logic [31:0] MAGIC        = 32'h0723_0203;
  localparam logic [2:0]  HEADER_WORDS = 3'd5;

  // opcodes
  localparam logic [15:0] OP_SOURCE_CONTINUED      = 16'd2;
  localparam logic [15:0] OP_SOURCE                = 16'd3;
  localparam logic [15:0] OP_STRING                = 16'd7;
  localparam logic [15:0] OP_LINE                  = 16'd8;
  localparam logic [15:0] OP_EXTENSION             = 16'd10;
  localparam logic [15:0] OP_MODULE_PROCESSED      = 16'd330;
  localparam logic [15:0] OP_DECORATE_ID           = 16'd332;
  localparam logic [15:0] OP_DECORATE_STRING       = 16'd5632;
  localparam logic [15:0] OP_MEMBER_DECORATE_STRING = 16'd5633;

  // decorations that make a DecorateId droppable
  localparam logic [31:0] DEC_COUNTER_BUFFER = 32'd5634;
  localparam logic [31:0] DEC_USER_TYPE      = 32'd5636;

  // padded extension names, little-endian words
  localparam int unsigned EXT_COUNT = 3;
  localparam logic [31:0] EXT_NAMES [EXT_COUNT][8] = '{
    '{32'h5F56_5053, 32'h474F_4F47, 32'h645F_454C, 32'h726F_6365,
      32'h5F65_7461, 32'h6972_7473, 32'h0000_676E, 32'h0000_0000},
    '{32'h5F56_5053, 32'h474F_4F47, 32'h685F_454C, 32'h5F6C_736C,
      32'h636E_7566, 32'h6E6F_6974, 32'h7469_6C61, 32'h0000_3179},
    '{32'h5F56_5053, 32'h474F_4F47, 32'h755F_454C, 32'h5F72_6573,
      32'h6570_7974, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
  };
  localparam logic [3:0] EXT_LEN [EXT_COUNT] = '{4'd7, 4'd8, 4'd6};

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_ZERO_LEN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KEEP_UNDECIDED = 2'd0,
    KEEP_YES       = 2'd1,
    KEEP_DROP      = 2'd2
  } keep_e;

  typedef struct packed {
    logic [31:0] word;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        is_end;
    status_e     status;
  } out_beat_t;

  // one parsed word: what the emitter must do with it
  typedef struct packed {
    logic [31:0]         word;
    logic                emit;
    logic                hold;
    logic [LA_IDX_W-1:0] hold_idx;
    logic [LA_CNT_W-1:0] rel_cnt;
    logic                is_end;
    status_e             status;
  } entry_t;

endpackage

[rtl/sdis_front.sv]
module sdis_front import sdis_pkg::*; #(
  parameter int unsigned LOOKAHEAD_DEPTH = LA_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_beat_t in_i,
  input  logic     q_full_i,
  output logic     push_o,
  output entry_t   entry_o
);

  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic [15:0] len_q, len_d;
  logic [15:0] wi_q, wi_d;
  logic [15:0] kind_q, kind_d;
  keep_e       keep_q, keep_d;
  logic [2:0]  flags_q, flags_d;
  status_e     err_q, err_d;

  logic        accept;
  logic        parsed;
  logic        hit;
  logic [16:0] wi1;
  logic [2:0]  ext_idx;
  keep_e       keep;
  logic [15:0] kind;
  logic [15:0] len;
  logic [2:0]  flags;
  entry_t      ent;

  assign accept = in_valid_i && !q_full_i;
  assign wi1     = {1'b0, wi_q} + 17'd1;
  assign ext_idx = wi_q[2:0] - 3'd1;

  // parse one word and build its queue entry
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    hdr_bad_d = hdr_bad_q;
    len_d     = len_q;
    wi_d      = wi_q;
    kind_d    = kind_q;
    keep_d    = keep_q;
    flags_d   = flags_q;
    err_d     = err_q;
    parsed    = 1'b0;
    hit       = 1'b0;
    keep      = keep_q;
    kind      = kind_q;
    len       = len_q;
    flags     = flags_q;
    ent        = '0;
    ent.word   = in_i.word;
    ent.status = ST_OK;

    if (accept) begin
      if (hdr_cnt_q < HEADER_WORDS) begin
        if (hdr_cnt_q == 3'd0 && in_i.word != MAGIC) begin
          hdr_bad_d = 1'b1;
        end
        hdr_cnt_d = hdr_cnt_q + 3'd1;
        ent.emit  = 1'b1;
      end else if (hdr_bad_q || err_q == ST_ZERO_LEN) begin
        ent.emit = 1'b1;
      end else begin
        parsed = 1'b1;
        // first word of an instruction
        if (wi_q == 16'd0) begin
          if (in_i.word[31:16] == 16'd0) begin
            err_d    = ST_ZERO_LEN;
            ent.emit = 1'b1;
            parsed   = 1'b0;
          end else begin
            len   = in_i.word[31:16];
            kind  = in_i.word[15:0];
            flags = 3'b111;
            if (in_i.word[15:0] inside {OP_SOURCE_CONTINUED, OP_SOURCE, OP_STRING,
                                        OP_LINE, OP_MODULE_PROCESSED,
                                        OP_DECORATE_STRING,
                                        OP_MEMBER_DECORATE_STRING}) begin
              keep = KEEP_DROP;
            end else begin
              keep = KEEP_UNDECIDED;
            end
          end
        end

        if (parsed) begin
          if (keep == KEEP_YES) begin
            ent.emit = 1'b1;
          end else if (keep == KEEP_UNDECIDED) begin
            if (wi_q < 16'(LOOKAHEAD_DEPTH)) begin
              ent.hold     = 1'b1;
              ent.hold_idx = LA_IDX_W'(wi_q);
            end
            // decide from the word just seen
            if (kind == OP_DECORATE_ID) begin
              if (wi_q == 16'd2) begin
                keep = (in_i.word == DEC_COUNTER_BUFFER || in_i.word == DEC_USER_TYPE) ?
                       KEEP_DROP : KEEP_YES;
              end
            end else if (kind == OP_EXTENSION) begin
              if (wi_q != 16'd0) begin
                for (int k = 0; k < EXT_COUNT; k++) begin
                  if (flags[k]) begin
                    if (wi_q > 16'(EXT_LEN[k]) || EXT_NAMES[k][ext_idx] != in_i.word) begin
                      flags[k] = 1'b0;
                    end else if (wi_q == 16'(EXT_LEN[k])) begin
                      hit = 1'b1;
                    end
                  end
                end
                if (hit) begin
                  keep = KEEP_DROP;
                end else if (flags == 3'b000) begin
                  keep = KEEP_YES;
                end
              end
            end else begin
              keep = KEEP_YES;
            end
            // end of instruction or of lookahead forces a keep
            if (keep == KEEP_UNDECIDED &&
                (wi1 == {1'b0, len} || wi1 >= 17'(LOOKAHEAD_DEPTH))) begin
              keep = KEEP_YES;
            end
            if (keep == KEEP_YES) begin
              ent.rel_cnt = LA_CNT_W'(wi1);
            end
          end

          if (wi1 >= {1'b0, len}) begin
            wi_d   = 16'd0;
            keep_d = KEEP_UNDECIDED;
          end else begin
            wi_d   = wi1[15:0];
            keep_d = keep;
          end
          kind_d  = kind;
          len_d   = len;
          flags_d = flags;
        end
      end

      // closing status beat
      if (in_i.last_word) begin
        ent.is_end = 1'b1;
        if (hdr_bad_d || hdr_cnt_d < HEADER_WORDS) begin
          ent.status = ST_BAD_HEADER;
        end else if (err_d == ST_ZERO_LEN) begin
          ent.status = ST_ZERO_LEN;
        end else if (wi_d != 16'd0) begin
          if (keep_d == KEEP_UNDECIDED) begin
            ent.rel_cnt = (wi_d > 16'(LOOKAHEAD_DEPTH)) ? LA_CNT_W'(LOOKAHEAD_DEPTH) :
                          LA_CNT_W'(wi_d);
          end
          ent.status = ST_TRUNCATED;
        end else begin
          ent.status = ST_OK;
        end
        hdr_cnt_d = 3'd0;
        hdr_bad_d = 1'b0;
        len_d     = 16'd0;
        wi_d      = 16'd0;
        kind_d    = 16'd0;
        keep_d    = KEEP_UNDECIDED;
        flags_d   = 3'b111;
        err_d     = ST_OK;
      end
    end
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.emit || ent.hold || ent.rel_cnt != '0 || ent.is_end);

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= 3'd0;
      hdr_bad_q <= 1'b0;
      len_q     <= 16'd0;
      wi_q      <= 16'd0;
      kind_q    <= 16'd0;
      keep_q    <= KEEP_UNDECIDED;
      flags_q   <= 3'b111;
      err_q     <= ST_OK;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      hdr_bad_q <= hdr_bad_d;
      len_q     <= len_d;
      wi_q      <= wi_d;
      kind_q    <= kind_d;
      keep_q    <= keep_d;
      flags_q   <= flags_d;
      err_q     <= err_d;
    end
  end

endmodule

[rtl/sdis_queue.sv]
module sdis_queue import sdis_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t head_o,
  input  logic   pop_i
);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d;
  logic [Q_PTR_W-1:0] rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = do_push ? wr_q + Q_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

[rtl/sdis_back.sv]
module sdis_back import sdis_pkg::*; #(
  parameter int unsigned LOOKAHEAD_DEPTH = LA_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  entry_t    head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_o
);

  localparam int unsigned IW = $clog2(LOOKAHEAD_DEPTH);

  logic [31:0]          la_q [LOOKAHEAD_DEPTH];
  logic [BEAT_CNT_W-1:0] pos_q, pos_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                  out_free;
  logic [BEAT_CNT_W-1:0] nbeats;
  logic [BEAT_CNT_W-1:0] rel_pos;
  logic [IW-1:0]         rd_idx;
  logic [IW-1:0]         wr_idx;
  logic [31:0]           rd_word;
  logic                  fire;
  logic                  beat;
  logic                  last_beat;
  logic                  la_we;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign nbeats    = BEAT_CNT_W'(head_i.emit) + BEAT_CNT_W'(head_i.rel_cnt) +
                     BEAT_CNT_W'(head_i.is_end);
  assign rel_pos   = pos_q - BEAT_CNT_W'(head_i.emit);
  assign rd_idx    = IW'(rel_pos);
  assign wr_idx    = IW'(head_i.hold_idx);
  assign fire      = head_valid_i && (nbeats == '0 || out_free);
  assign beat      = head_valid_i && nbeats != '0 && out_free;
  assign last_beat = (nbeats == '0) || (pos_q == nbeats - BEAT_CNT_W'(1));
  assign pop_o     = fire && last_beat;
  assign la_we     = fire && pos_q == '0 && head_i.hold;

  // held word, bypassing the write of this entry
  assign rd_word = (head_i.hold && rd_idx == wr_idx) ? head_i.word : la_q[rd_idx];

  // beat sequencing over one entry
  always_comb begin
    pos_d = pos_q;
    if (pop_o) begin
      pos_d = '0;
    end else if (beat) begin
      pos_d = pos_q + BEAT_CNT_W'(1);
    end
  end

  // beat selection for the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = beat;
    end
    if (beat) begin
      if (head_i.emit && pos_q == '0) begin
        out_d.out_word = head_i.word;
        out_d.is_end   = 1'b0;
        out_d.status   = ST_OK;
      end else if (rel_pos < BEAT_CNT_W'(head_i.rel_cnt)) begin
        out_d.out_word = rd_word;
        out_d.is_end   = 1'b0;
        out_d.status   = ST_OK;
      end else begin
        out_d.out_word = 32'd0;
        out_d.is_end   = 1'b1;
        out_d.status   = head_i.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // lookahead buffer
  always_ff @(posedge clk_i) begin
    if (la_we) begin
      la_q[wr_idx] <= head_i.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/spirv_debug_instruction_stripper_top.sv]
// channel  | direction | valid       | stall       | payload
// ---------+-----------+-------------+-------------+----------------------------
// in       | input     | in_valid_i  | in_stall_o  | in_i  (word, last_word)
// out      | output    | out_valid_o | out_stall_i | out_o (out_word, is_end, status)
//
// one word is accepted per cycle while the parser queue has room; a kept word
// is registered in the queue and then in the output register.
// an undecided instruction is held in the lookahead buffer and released one word
// per cycle once kept, unless the output stalls; an item that releases n held words
// gives n output beats (up to LOOKAHEAD_DEPTH + 1 with the closing status beat).
// reset is asynchronous: queue empty, parser waiting for the first header word.
// in_stall_o rises only when the four-entry queue is full.
module spirv_debug_instruction_stripper_top import sdis_pkg::*; #(
  parameter int unsigned LOOKAHEAD_DEPTH = LA_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_o
);

  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;
  entry_t q_head;

  assign in_stall_o = q_full;

  // parser front
  sdis_front #(
    .LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .entry_o   (q_entry)
  );

  // decoupling queue
  sdis_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  // emitter back
  sdis_back #(
    .LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("push into full queue");

  // pop only with a queued entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // status beat carries a zero word, word beats carry ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_end |-> out_o.out_word == 32'd0)
    else $error("status beat with nonzero word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.is_end |-> out_o.status == ST_OK)
    else $error("word beat with nonzero status");

endmodule
